@@ rtl/rlse_pkg.sv @@
// ----------------------------------------------------------------------------
// RGB LED serial line encoder package
// Shared types and constants for the pixel front end, queue and symbol back end.
// ----------------------------------------------------------------------------
`default_nettype none

package rlse_pkg;

   localparam int SYMBOLS_PER_PIXEL = 24;
   localparam int SYM_CNT_W         = 5;
   localparam int QUEUE_DEPTH       = 2;
   localparam int QUEUE_PTR_W       = 1;
   localparam int QUEUE_CNT_W       = 2;
   localparam int CSR_INDEX_W       = 3;
   localparam int CSR_DATA_W        = 16;

   localparam logic [SYM_CNT_W-1:0] LAST_BIT_IDX  = SYM_CNT_W'(SYMBOLS_PER_PIXEL - 1);
   localparam logic [SYM_CNT_W-1:0] LATCH_SYM_IDX = SYM_CNT_W'(SYMBOLS_PER_PIXEL);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ZERO_HIGH = 3'd0,
      CSR_ZERO_LOW  = 3'd1,
      CSR_ONE_HIGH  = 3'd2,
      CSR_ONE_LOW   = 3'd3,
      CSR_LATCH_LOW = 3'd4
   } csr_index_type;

   localparam logic [11:0] ZERO_HIGH_RESET = 12'd34;
   localparam logic [11:0] ZERO_LOW_RESET  = 12'd71;
   localparam logic [11:0] ONE_HIGH_RESET  = 12'd67;
   localparam logic [11:0] ONE_LOW_RESET   = 12'd38;
   localparam logic [15:0] LATCH_LOW_RESET = 16'd6720;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       end_of_frame;
   } req_type;

   typedef struct packed {
      logic [11:0] high_cycles;
      logic [15:0] low_cycles;
      logic        last;
   } rsp_type;

   // One queued pixel: line order bits (green, red, blue, MSB first) and the frame flag.
   typedef struct packed {
      logic [SYMBOLS_PER_PIXEL-1:0] bits;
      logic                         eof;
   } entry_type;

   typedef struct packed {
      logic [11:0] zero_high;
      logic [11:0] zero_low;
      logic [11:0] one_high;
      logic [11:0] one_low;
      logic [15:0] latch_low;
   } timing_type;

   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

endpackage

`default_nettype wire

@@ rtl/rgb_led_serial_line_encoder_top.sv @@
// ----------------------------------------------------------------------------
// RGB LED serial line encoder
// Turns pixels into timed bit symbols for a single-wire LED chain.
// ----------------------------------------------------------------------------
// Each pixel accepted on start produces 24 symbol beats on rsp_valid, one per
// clock, green then red then blue, MSB first, plus a latch beat when
// end_of_frame is set; the back end's bit shifter sends one symbol a cycle.
// A holding register and a two-entry queue let start be taken in back-to-back
// cycles until they fill; busy then stays high until the back end frees a
// slot. The first symbol passes through the holding register, a queue slot,
// the back end's shift register and its output register. rsp_valid is a
// strobe: each beat must be taken in the cycle it is shown.
`default_nettype none

module rgb_led_serial_line_encoder_top (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   output logic                                busy,
   input  rlse_pkg::req_type                   req_pixel,
   output logic                                rsp_valid,
   output rlse_pkg::rsp_type                   rsp_symbol,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [rlse_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire  [rlse_pkg::CSR_DATA_W-1:0]     csr_data
);
   import rlse_pkg::*;

   timing_type       timing_ff, timing_in;
   queue_status_type q_status;
   entry_type        push_entry, pop_entry;
   logic             push, pop;

   assign csr_ready = 1'b1;

   always_comb begin
      timing_in = timing_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ZERO_HIGH: timing_in.zero_high = csr_data[11:0];
            CSR_ZERO_LOW:  timing_in.zero_low  = csr_data[11:0];
            CSR_ONE_HIGH:  timing_in.one_high  = csr_data[11:0];
            CSR_ONE_LOW:   timing_in.one_low   = csr_data[11:0];
            CSR_LATCH_LOW: timing_in.latch_low = csr_data;
            default:       timing_in = timing_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.zero_high <= ZERO_HIGH_RESET;
         timing_ff.zero_low  <= ZERO_LOW_RESET;
         timing_ff.one_high  <= ONE_HIGH_RESET;
         timing_ff.one_low   <= ONE_LOW_RESET;
         timing_ff.latch_low <= LATCH_LOW_RESET;
      end else begin
         timing_ff <= timing_in;
      end
   end

   rlse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_pixel  (req_pixel),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   rlse_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (q_status)
   );

   rlse_back u_back (
      .clock      (clock),
      .reset      (reset),
      .timing     (timing_ff),
      .q_status   (q_status),
      .q_entry    (pop_entry),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_symbol (rsp_symbol)
   );

endmodule

`default_nettype wire

@@ rtl/rlse_front.sv @@
// ----------------------------------------------------------------------------
// RGB LED serial line encoder front end
// Accepts pixel commands, packs them in line order and pushes them to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rlse_front (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   output logic                       busy,
   input  rlse_pkg::req_type          req_pixel,
   input  rlse_pkg::queue_status_type q_status,
   output logic                       push,
   output rlse_pkg::entry_type        push_entry
);
   import rlse_pkg::*;

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   logic      accept;

   // The holding register drains into the queue whenever the queue has room.
   assign push   = valid_ff & ~q_status.full;
   assign busy   = valid_ff & q_status.full;
   assign accept = start & ~busy;

   always_comb begin
      valid_in = accept | (valid_ff & ~push);
      if (accept) begin
         entry_in.bits = {req_pixel.green, req_pixel.red, req_pixel.blue};
         entry_in.eof  = req_pixel.end_of_frame;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign push_entry = entry_ff;

endmodule

`default_nettype wire

@@ rtl/rlse_queue.sv @@
// ----------------------------------------------------------------------------
// RGB LED serial line encoder queue
// Short FIFO of packed pixels between the front end and the symbol back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rlse_queue (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push,
   input  rlse_pkg::entry_type        push_entry,
   input  wire                        pop,
   output rlse_pkg::entry_type        pop_entry,
   output rlse_pkg::queue_status_type status
);
   import rlse_pkg::*;

   entry_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                    do_push, do_pop;

   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.valid = (count_ff != '0);
   assign do_push      = push & ~status.full;
   assign do_pop       = pop & status.valid;
   assign pop_entry    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

@@ rtl/rlse_back.sv @@
// ----------------------------------------------------------------------------
// RGB LED serial line encoder back end
// Shifts out one bit symbol per cycle and appends the latch pulse on frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module rlse_back (
   input  wire                        clock,
   input  wire                        reset,
   input  rlse_pkg::timing_type       timing,
   input  rlse_pkg::queue_status_type q_status,
   input  rlse_pkg::entry_type        q_entry,
   output logic                       pop,
   output logic                       rsp_valid,
   output rlse_pkg::rsp_type          rsp_symbol
);
   import rlse_pkg::*;

   logic                         active_ff, active_in;
   logic [SYMBOLS_PER_PIXEL-1:0] shift_ff, shift_in;
   logic                         eof_ff, eof_in;
   logic [SYM_CNT_W-1:0]         count_ff, count_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_type                      rsp_ff, rsp_in;
   logic                         is_latch, finishing;

   assign is_latch  = (count_ff == LATCH_SYM_IDX);
   assign finishing = active_ff & (is_latch | ((count_ff == LAST_BIT_IDX) & ~eof_ff));
   // The next pixel loads in the cycle its predecessor sends its final symbol.
   assign pop       = q_status.valid & (~active_ff | finishing);

   always_comb begin
      active_in = active_ff;
      shift_in  = shift_ff;
      eof_in    = eof_ff;
      count_in  = count_ff;
      if (pop) begin
         active_in = 1'b1;
         shift_in  = q_entry.bits;
         eof_in    = q_entry.eof;
         count_in  = '0;
      end else if (finishing) begin
         active_in = 1'b0;
      end else if (active_ff) begin
         shift_in = {shift_ff[SYMBOLS_PER_PIXEL-2:0], 1'b0};
         count_in = count_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = active_ff;
      if (is_latch) begin
         rsp_in.high_cycles = '0;
         rsp_in.low_cycles  = timing.latch_low;
         rsp_in.last        = 1'b1;
      end else begin
         if (shift_ff[SYMBOLS_PER_PIXEL-1]) begin
            rsp_in.high_cycles = timing.one_high;
            rsp_in.low_cycles  = {4'd0, timing.one_low};
         end else begin
            rsp_in.high_cycles = timing.zero_high;
            rsp_in.low_cycles  = {4'd0, timing.zero_low};
         end
         rsp_in.last = (count_ff == LAST_BIT_IDX) & ~eof_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      shift_ff <= shift_in;
      eof_ff   <= eof_in;
      count_ff <= count_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_ff;

endmodule

`default_nettype wire
